// ===== rtl/terminal_key_sequence_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the terminal key sequence decoder
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef TERMINAL_KEY_SEQUENCE_DECODER_ASSERT_SVH
`define TERMINAL_KEY_SEQUENCE_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TKSD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TKSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/tksd_pkg.sv =====
// ----------------------------------------------------------------------------
// Terminal key sequence decoder package
// Parser phases, character and key code constants, shared structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tksd_pkg;

    typedef enum logic [9:0] {
        PH_IDLE  = 10'b00_0000_0001,
        PH_ESC   = 10'b00_0000_0010,
        PH_CSI   = 10'b00_0000_0100,
        PH_TILDE = 10'b00_0000_1000,
        PH_CSI1  = 10'b00_0001_0000,
        PH_MOD   = 10'b00_0010_0000,
        PH_CTRL  = 10'b00_0100_0000,
        PH_SHIFT = 10'b00_1000_0000,
        PH_SS3   = 10'b01_0000_0000,
        PH_ESC1  = 10'b10_0000_0000
    } t_phase;

    // Input characters.
    localparam logic [7:0] CH_ESC     = 8'd27;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_O       = 8'h4F;
    localparam logic [7:0] CH_ONE     = 8'h31;
    localparam logic [7:0] CH_TWO     = 8'h32;
    localparam logic [7:0] CH_THREE   = 8'h33;
    localparam logic [7:0] CH_FIVE    = 8'h35;
    localparam logic [7:0] CH_SIX     = 8'h36;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_TILDE   = 8'h7E;
    localparam logic [7:0] CH_A       = 8'h41;
    localparam logic [7:0] CH_D       = 8'h44;
    localparam logic [7:0] CH_F       = 8'h46;
    localparam logic [7:0] CH_H       = 8'h48;
    localparam logic [7:0] CH_P       = 8'h50;
    localparam logic [7:0] CH_S       = 8'h53;
    localparam logic [7:0] CH_LC_T    = 8'h74;
    localparam logic [7:0] CH_LC_V    = 8'h76;
    localparam logic [7:0] CH_LC_W    = 8'h77;
    localparam logic [7:0] CH_LC_Y    = 8'h79;

    // Key codes.
    localparam logic [7:0] KEY_UP         = 8'd128;
    localparam logic [7:0] KEY_CTRL_UP    = 8'd132;
    localparam logic [7:0] KEY_PGUP       = 8'd136;
    localparam logic [7:0] KEY_PGDN       = 8'd137;
    localparam logic [7:0] KEY_CTRL_HOME  = 8'd138;
    localparam logic [7:0] KEY_HOME       = 8'd140;
    localparam logic [7:0] KEY_END        = 8'd141;
    localparam logic [7:0] KEY_INSERT     = 8'd142;
    localparam logic [7:0] KEY_DELETE     = 8'd143;
    localparam logic [7:0] KEY_F1         = 8'd144;
    localparam logic [7:0] KEY_F5         = 8'd148;
    localparam logic [7:0] KEY_F8         = 8'd151;
    localparam logic [7:0] KEY_F11        = 8'd154;
    localparam logic [7:0] KEY_F12        = 8'd155;
    localparam logic [7:0] KEY_SHIFT_UP   = 8'd156;
    localparam logic [7:0] KEY_SHIFT_HOME = 8'd160;
    localparam logic [7:0] KEY_NONE       = 8'd0;

    typedef struct packed {
        logic [7:0] key_code;
        logic       is_plain;
        logic       invalid;
    } t_key_result;

    typedef struct packed {
        logic        emit;
        t_key_result key;
    } t_dec_out;

endpackage

// ===== rtl/tksd_if.sv =====
// ----------------------------------------------------------------------------
// Terminal key sequence decoder channels
// Valid/ready channels for received bytes and decoded keys.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tksd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tksd_key_if;
    logic       valid;
    logic       ready;
    logic [7:0] key_code;
    logic       is_plain;
    logic       invalid;

    modport source (output valid, output key_code, output is_plain, output invalid,
                    input ready);
    modport sink   (input valid, input key_code, input is_plain, input invalid,
                    output ready);
endinterface

// ===== rtl/tksd_in_stage.sv =====
// ----------------------------------------------------------------------------
// Input byte register
// Captures one received byte and holds it until the decoder takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tksd_in_stage (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tksd_byte_if.sink   i_rx,
    input  logic        i_advance,
    output logic        o_valid,
    output logic [7:0]  o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    // The register can refill in the same cycle in which it drains.
    assign i_rx.ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

// ===== rtl/tksd_decode.sv =====
// ----------------------------------------------------------------------------
// Sequence parser
// Parse phase and pending key registers with the byte decode logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tksd_decode
    import tksd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    output t_dec_out   o_dec
);

    t_phase     r_phase;
    t_phase     n_phase;
    logic [7:0] r_pending;
    logic [7:0] n_pending;
    t_dec_out   dec;

    logic is_arrow;
    logic is_f1_4;
    logic is_f5_7;
    logic is_f8_10;

    assign is_arrow = (i_byte >= CH_A) && (i_byte <= CH_D);
    assign is_f1_4  = (i_byte >= CH_P) && (i_byte <= CH_S);
    assign is_f5_7  = (i_byte >= CH_LC_T) && (i_byte <= CH_LC_V);
    assign is_f8_10 = (i_byte >= CH_LC_W) && (i_byte <= CH_LC_Y);

    always_comb begin
        n_phase      = r_phase;
        n_pending    = r_pending;
        dec.emit     = 1'b0;
        dec.key      = '{key_code: KEY_NONE, is_plain: 1'b0, invalid: 1'b0};

        unique case (r_phase)
            PH_ESC: begin
                if (i_byte == CH_LBRACK) begin
                    n_phase = PH_CSI;
                end else if (i_byte == CH_O) begin
                    n_phase = PH_SS3;
                end else if (i_byte == CH_ONE) begin
                    n_phase = PH_ESC1;
                end else begin
                    dec.emit        = 1'b1;
                    dec.key.invalid = 1'b1;
                end
            end
            PH_CSI: begin
                if (is_arrow) begin
                    dec.emit         = 1'b1;
                    dec.key.key_code = 8'(KEY_UP + (i_byte - CH_A));
                end else if (i_byte == CH_H) begin
                    dec.emit         = 1'b1;
                    dec.key.key_code = KEY_HOME;
                end else if (i_byte == CH_F) begin
                    dec.emit         = 1'b1;
                    dec.key.key_code = KEY_END;
                end else if (i_byte == CH_TWO) begin
                    n_phase   = PH_TILDE;
                    n_pending = KEY_INSERT;
                end else if (i_byte == CH_THREE) begin
                    n_phase   = PH_TILDE;
                    n_pending = KEY_DELETE;
                end else if (i_byte == CH_FIVE) begin
                    n_phase   = PH_TILDE;
                    n_pending = KEY_PGUP;
                end else if (i_byte == CH_SIX) begin
                    n_phase   = PH_TILDE;
                    n_pending = KEY_PGDN;
                end else if (i_byte == CH_ONE) begin
                    n_phase = PH_CSI1;
                end else begin
                    dec.emit        = 1'b1;
                    dec.key.invalid = 1'b1;
                end
            end
            PH_TILDE: begin
                dec.emit = 1'b1;
                if (i_byte == CH_TILDE) begin
                    dec.key.key_code = r_pending;
                end else begin
                    dec.key.invalid = 1'b1;
                end
            end
            PH_CSI1: begin
                if (i_byte == CH_SEMI) begin
                    n_phase = PH_MOD;
                end else begin
                    dec.emit        = 1'b1;
                    dec.key.invalid = 1'b1;
                end
            end
            PH_MOD: begin
                if (i_byte == CH_FIVE) begin
                    n_phase = PH_CTRL;
                end else if (i_byte == CH_TWO) begin
                    n_phase = PH_SHIFT;
                end else begin
                    dec.emit        = 1'b1;
                    dec.key.invalid = 1'b1;
                end
            end
            PH_CTRL, PH_SHIFT: begin
                // Both modifiers map A..D, H, F onto six codes: four arrow codes, then Home and End.
                dec.emit = 1'b1;
                if (is_arrow) begin
                    dec.key.key_code = (r_phase == PH_CTRL)
                        ? 8'(KEY_CTRL_UP + (i_byte - CH_A))
                        : 8'(KEY_SHIFT_UP + (i_byte - CH_A));
                end else if (i_byte == CH_H) begin
                    dec.key.key_code = (r_phase == PH_CTRL) ? KEY_CTRL_HOME
                                                            : KEY_SHIFT_HOME;
                end else if (i_byte == CH_F) begin
                    dec.key.key_code = (r_phase == PH_CTRL)
                        ? 8'(KEY_CTRL_HOME + 8'd1)
                        : 8'(KEY_SHIFT_HOME + 8'd1);
                end else begin
                    dec.key.invalid = 1'b1;
                end
            end
            PH_SS3: begin
                dec.emit = 1'b1;
                if (is_f1_4) begin
                    dec.key.key_code = 8'(KEY_F1 + (i_byte - CH_P));
                end else if (is_f5_7) begin
                    dec.key.key_code = 8'(KEY_F5 + (i_byte - CH_LC_T));
                end else if (is_f8_10) begin
                    dec.key.key_code = 8'(KEY_F8 + (i_byte - CH_LC_W));
                end else begin
                    dec.key.invalid = 1'b1;
                end
            end
            PH_ESC1: begin
                if (i_byte == CH_ONE) begin
                    n_phase   = PH_TILDE;
                    n_pending = KEY_F11;
                end else if (i_byte == CH_TWO) begin
                    n_phase   = PH_TILDE;
                    n_pending = KEY_F12;
                end else begin
                    dec.emit        = 1'b1;
                    dec.key.invalid = 1'b1;
                end
            end
            default: begin
                // Idle, and any code that is not a phase, behave the same.
                if (i_byte == CH_ESC) begin
                    n_phase = PH_ESC;
                end else begin
                    dec.emit         = 1'b1;
                    dec.key.key_code = i_byte;
                    dec.key.is_plain = 1'b1;
                end
            end
        endcase

        // Every result closes the sequence.
        if (dec.emit) begin
            n_phase = PH_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_pending <= KEY_NONE;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_pending <= n_pending;
        end
    end

    assign o_dec = dec;

endmodule

// ===== rtl/tksd_out_stage.sv =====
// ----------------------------------------------------------------------------
// Result register
// Holds one decoded key until the downstream side takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tksd_out_stage
    import tksd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_key_result i_key,
    output logic        o_free,
    tksd_key_if.source  o_key
);

    logic        r_valid;
    t_key_result r_key;

    assign o_free = !r_valid || o_key.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_key <= i_key;
        end
    end

    assign o_key.valid    = r_valid;
    assign o_key.key_code = r_key.key_code;
    assign o_key.is_plain = r_key.is_plain;
    assign o_key.invalid  = r_key.invalid;

endmodule

// ===== rtl/terminal_key_sequence_decoder.sv =====
// ----------------------------------------------------------------------------
// Terminal key sequence decoder
// Turns received terminal bytes into plain or special key codes.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Transaction
//   i_rx      in          one received byte (rx_byte)
//   o_key     out         one key (key_code, is_plain, invalid)
//
// One byte is accepted per cycle unless o_key stalls; the byte that completes
// a key passes the input register, then its key enters the result register.
// Bytes inside a sequence update the parse phase and give no transaction.
// Reset clears the parse phase, the pending key and both valid flags.
// When o_key stalls, the input register holds its byte and i_rx.ready drops
// once it is full, so the parser never advances past an undelivered key.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module terminal_key_sequence_decoder
    import tksd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    tksd_byte_if.sink   i_rx,
    tksd_key_if.source  o_key
);

    logic       byte_valid;
    logic [7:0] byte_q;
    logic       out_free;
    logic       fire;
    t_dec_out   dec;

    assign fire = byte_valid && out_free;

    tksd_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rx      (i_rx),
        .i_advance (fire),
        .o_valid   (byte_valid),
        .o_byte    (byte_q)
    );

    tksd_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (byte_q),
        .o_dec   (dec)
    );

    tksd_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire && dec.emit),
        .i_key   (dec.key),
        .o_free  (out_free),
        .o_key   (o_key)
    );

endmodule

// ===== rtl/tksd_checker.sv =====
// ----------------------------------------------------------------------------
// Terminal key sequence decoder port checker
// Checks key results and the output handshake seen at the top level ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "terminal_key_sequence_decoder_assert.svh"

module tksd_checker
    import tksd_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_key_code,
    input logic       i_is_plain,
    input logic       i_invalid
);

    logic        out_invalid;
    logic        invalid_ok;
    logic        out_special;
    logic        special_ok;
    logic        out_plain_esc;
    logic        stalled;
    logic [10:0] out_word;

    assign out_invalid   = i_out_valid && i_invalid;
    assign invalid_ok    = (i_key_code == KEY_NONE) && !i_is_plain;
    assign out_special   = i_out_valid && !i_is_plain && !i_invalid;
    // Special codes run from the first arrow up to Shift-End.
    assign special_ok    = (i_key_code >= KEY_UP)
                        && (i_key_code <= 8'(KEY_SHIFT_HOME + 8'd1));
    assign out_plain_esc = i_out_valid && i_is_plain && (i_key_code == CH_ESC);
    assign stalled       = i_out_valid && !i_out_ready;
    assign out_word      = {i_out_valid, i_key_code, i_is_plain, i_invalid};

    `TKSD_ASSERT_SAME(a_invalid, i_clk, i_rst_n, out_invalid, invalid_ok, "bad invalid key")
    `TKSD_ASSERT_SAME(a_special, i_clk, i_rst_n, out_special, special_ok, "bad special code")
    `TKSD_ASSERT_NEXT(a_no_esc, i_clk, i_rst_n, 1'b1, !out_plain_esc, "plain escape key")
    `TKSD_ASSERT_NEXT(a_stall, i_clk, i_rst_n, stalled, $stable(out_word), "stalled key changed")

endmodule

bind terminal_key_sequence_decoder tksd_checker u_tksd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_key.valid),
    .i_out_ready (o_key.ready),
    .i_key_code  (o_key.key_code),
    .i_is_plain  (o_key.is_plain),
    .i_invalid   (o_key.invalid)
);

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// Terminal key sequence decoder testbench
// Feeds byte streams of plain keys, complete escape sequences and broken
// ones, predicts each decoded key and checks every key transaction against
// it while both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import tksd_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 60;
    localparam int TARGET_BYTES = 450;
    localparam int IDLE_PERCENT = 28;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tksd_byte_if rx_ch ();
    tksd_key_if  key_ch ();

    terminal_key_sequence_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_key   (key_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Decoder state as the bench sees it.
    t_phase      parse_state = PH_IDLE;
    logic [7:0]  tilde_key   = KEY_NONE;
    t_key_result expected_keys[$];

    bit steady       = 1'b0;
    bit hold_request = 1'b0;
    int bytes_sent   = 0;
    int keys_checked = 0;
    int plain_keys   = 0;
    int special_keys = 0;
    int invalid_keys = 0;
    int failures     = 0;
    int cycle_count  = 0;

    function automatic t_key_result special(input logic [7:0] code);
        return '{key_code: code, is_plain: 1'b0, invalid: 1'b0};
    endfunction

    // Advances the parser by one byte; got_key tells whether a key results.
    function automatic void decode_byte(input logic [7:0] b, output bit got_key,
                                        output t_key_result key);
        logic [7:0] arrow_base;
        logic [7:0] home_base;
        got_key    = 1'b1;
        key        = '{key_code: KEY_NONE, is_plain: 1'b0, invalid: 1'b1};
        arrow_base = (parse_state == PH_CTRL) ? KEY_CTRL_UP : KEY_SHIFT_UP;
        home_base  = (parse_state == PH_CTRL) ? KEY_CTRL_HOME : KEY_SHIFT_HOME;
        case (parse_state)
            PH_ESC: begin
                got_key = 1'b0;
                if (b == CH_LBRACK) parse_state = PH_CSI;
                else if (b == CH_O) parse_state = PH_SS3;
                else if (b == CH_ONE) parse_state = PH_ESC1;
                else got_key = 1'b1;
            end
            PH_CSI: begin
                if (b >= CH_A && b <= CH_D) key = special(KEY_UP + (b - CH_A));
                else if (b == CH_H) key = special(KEY_HOME);
                else if (b == CH_F) key = special(KEY_END);
                else if (b == CH_ONE) begin
                    got_key = 1'b0;
                    parse_state = PH_CSI1;
                end else if (b == CH_TWO || b == CH_THREE || b == CH_FIVE || b == CH_SIX) begin
                    got_key = 1'b0;
                    parse_state = PH_TILDE;
                    case (b)
                        CH_TWO:   tilde_key = KEY_INSERT;
                        CH_THREE: tilde_key = KEY_DELETE;
                        CH_FIVE:  tilde_key = KEY_PGUP;
                        default:  tilde_key = KEY_PGDN;
                    endcase
                end
            end
            PH_TILDE: begin
                if (b == CH_TILDE) key = special(tilde_key);
            end
            PH_CSI1: begin
                if (b == CH_SEMI) begin
                    got_key = 1'b0;
                    parse_state = PH_MOD;
                end
            end
            PH_MOD: begin
                if (b == CH_FIVE) begin
                    got_key = 1'b0;
                    parse_state = PH_CTRL;
                end else if (b == CH_TWO) begin
                    got_key = 1'b0;
                    parse_state = PH_SHIFT;
                end
            end
            PH_CTRL, PH_SHIFT: begin
                if (b >= CH_A && b <= CH_D) key = special(arrow_base + (b - CH_A));
                else if (b == CH_H) key = special(home_base);
                else if (b == CH_F) key = special(home_base + 8'd1);
            end
            PH_SS3: begin
                if (b >= CH_P && b <= CH_S) key = special(KEY_F1 + (b - CH_P));
                else if (b >= CH_LC_T && b <= CH_LC_V) key = special(KEY_F5 + (b - CH_LC_T));
                else if (b >= CH_LC_W && b <= CH_LC_Y) key = special(KEY_F8 + (b - CH_LC_W));
            end
            PH_ESC1: begin
                if (b == CH_ONE || b == CH_TWO) begin
                    got_key = 1'b0;
                    parse_state = PH_TILDE;
                    tilde_key = (b == CH_ONE) ? KEY_F11 : KEY_F12;
                end
            end
            default: begin
                if (b == CH_ESC) begin
                    got_key = 1'b0;
                    parse_state = PH_ESC;
                end else begin
                    key = '{key_code: b, is_plain: 1'b1, invalid: 1'b0};
                end
            end
        endcase
        if (got_key) parse_state = PH_IDLE;
    endfunction

    // Offers one byte, waits for the transaction and records the predicted key.
    task automatic send_byte(input logic [7:0] b);
        bit          got_key;
        t_key_result key;
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            rx_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge i_clk); while (!rx_ch.ready);
        decode_byte(b, got_key, key);
        if (got_key) expected_keys.push_back(key);
        bytes_sent++;
    endtask

    function automatic logic [7:0] pick_letter();
        case ($urandom_range(0, 5))
            0, 1, 2, 3: pick_letter = CH_A + 8'($urandom_range(0, 3));
            4:          pick_letter = CH_H;
            default:    pick_letter = CH_F;
        endcase
    endfunction

    function automatic logic [7:0] pick_function_char();
        int idx;
        idx = $urandom_range(0, 9);
        if (idx < 4) pick_function_char = CH_P + 8'(idx);
        else if (idx < 7) pick_function_char = CH_LC_T + 8'(idx - 4);
        else pick_function_char = CH_LC_W + 8'(idx - 7);
    endfunction

    function automatic logic [7:0] pick_tilde_digit();
        case ($urandom_range(0, 3))
            0:       pick_tilde_digit = CH_TWO;
            1:       pick_tilde_digit = CH_THREE;
            2:       pick_tilde_digit = CH_FIVE;
            default: pick_tilde_digit = CH_SIX;
        endcase
    endfunction

    // A complete sequence of random kind, or a prefix of one ended by a stray byte.
    task automatic send_random_sequence(input bit broken);
        logic [7:0] seq[$];
        int         kind;
        int         cut;
        kind = $urandom_range(0, 5);
        seq.push_back(CH_ESC);
        case (kind)
            0: begin
                seq.push_back(CH_LBRACK);
                seq.push_back(pick_letter());
            end
            1: begin
                seq.push_back(CH_LBRACK);
                seq.push_back(pick_tilde_digit());
                seq.push_back(CH_TILDE);
            end
            2, 3: begin
                seq.push_back(CH_LBRACK);
                seq.push_back(CH_ONE);
                seq.push_back(CH_SEMI);
                seq.push_back(kind == 2 ? CH_FIVE : CH_TWO);
                seq.push_back(pick_letter());
            end
            4: begin
                seq.push_back(CH_O);
                seq.push_back(pick_function_char());
            end
            default: begin
                seq.push_back(CH_ONE);
                seq.push_back($urandom_range(0, 1) ? CH_ONE : CH_TWO);
                seq.push_back(CH_TILDE);
            end
        endcase
        if (broken) begin
            cut = $urandom_range(1, seq.size() - 1);
            while (seq.size() > cut) void'(seq.pop_back());
            seq.push_back($urandom_range(0, 4) == 0 ? CH_ESC : 8'($urandom_range(0, 255)));
        end
        foreach (seq[i]) send_byte(seq[i]);
    endtask

    task automatic test_plain_extremes();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
    endtask

    task automatic test_directed_sequences();
        send_byte(CH_ESC);
        send_byte(CH_LBRACK);
        send_byte(CH_A);
        send_byte(CH_ESC);
        send_byte(CH_LBRACK);
        send_byte(CH_ONE);
        send_byte(CH_SEMI);
        send_byte(CH_FIVE);
        send_byte(CH_H);
        send_byte(CH_ESC);
        send_byte(CH_O);
        send_byte(CH_LC_Y);
        send_byte(CH_ESC);
        send_byte(CH_ONE);
        send_byte(CH_TWO);
        send_byte(CH_TILDE);
    endtask

    task automatic test_broken_sequences();
        // A second escape breaks the pending sequence instead of restarting it.
        send_byte(CH_ESC);
        send_byte(CH_ESC);
        send_byte(CH_ESC);
        send_byte(CH_LBRACK);
        send_byte(CH_TWO);
        send_byte(8'h78);
    endtask

    task automatic test_output_stall();
        hold_request = 1'b1;
        repeat (20) send_byte(8'($urandom_range(32, 126)));
    endtask

    task automatic test_random_streams();
        int pick;
        steady = 1'b1;
        while (bytes_sent < TARGET_BYTES) begin
            if (bytes_sent > 150) steady = 1'b0;
            pick = $urandom_range(99);
            if (pick < 55) send_random_sequence(1'b0);
            else if (pick < 75) send_random_sequence(1'b1);
            else repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end
        steady = 1'b0;
    endtask

    // Key receiver: random stalls, plus one long hold-off on request.
    initial begin
        int hold_left = 0;
        key_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                key_ch.ready <= 1'b0;
            end else begin
                key_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    always @(posedge i_clk) begin
        t_key_result exp_key;
        if (i_rst_n && key_ch.valid && key_ch.ready) begin
            keys_checked++;
            if (expected_keys.size() == 0) begin
                failures++;
                $display("%0t: unexpected key transaction code=%0d plain=%0b invalid=%0b",
                         $time, key_ch.key_code, key_ch.is_plain, key_ch.invalid);
            end else begin
                exp_key = expected_keys.pop_front();
                if (key_ch.key_code !== exp_key.key_code) begin
                    failures++;
                    $display("%0t: key_code expected %0d actual %0d",
                             $time, exp_key.key_code, key_ch.key_code);
                end
                if (key_ch.is_plain !== exp_key.is_plain) begin
                    failures++;
                    $display("%0t: is_plain expected %0b actual %0b",
                             $time, exp_key.is_plain, key_ch.is_plain);
                end
                if (key_ch.invalid !== exp_key.invalid) begin
                    failures++;
                    $display("%0t: invalid expected %0b actual %0b",
                             $time, exp_key.invalid, key_ch.invalid);
                end
                if (exp_key.invalid) invalid_keys++;
                else if (exp_key.is_plain) plain_keys++;
                else special_keys++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d keys outstanding", $time, expected_keys.size());
            $display("FAIL terminal_key_sequence_decoder");
            $finish;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= 8'h00;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_plain_extremes();
        test_directed_sequences();
        test_broken_sequences();
        test_output_stall();
        test_random_streams();

        rx_ch.valid <= 1'b0;
        while (expected_keys.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (expected_keys.size() != 0) failures++;

        $display("Sent %0d bytes; checked %0d keys: %0d plain, %0d special, %0d invalid.",
                 bytes_sent, keys_checked, plain_keys, special_keys, invalid_keys);
        if (failures == 0) begin
            $display("PASS terminal_key_sequence_decoder");
        end else begin
            $display("%0d mismatches found.", failures);
            $display("FAIL terminal_key_sequence_decoder");
        end
        $finish;
    end

endmodule
